// ===== hw/rtl/cq_pkg.sv =====
// Shared constants, codes and types of the circular queue core.
`default_nettype none

package cq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHOW  = 2'd3;

  localparam logic [STAT_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEQ   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] ST_QUERY = 3'd4;
  localparam logic [STAT_W-1:0] ST_SHOW  = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ENQ,
    OP_FULL,
    OP_DEQ,
    OP_EMPTY,
    OP_QUERY,
    OP_SHOW_FIRST,
    OP_SHOW_NEXT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circular_queue_core.sv =====
// Top level of the circular queue core: controller and datapath.
//
//  channel  | ports                                            | handshake
//  ---------+--------------------------------------------------+--------------------------
//  command  | command_i, value_i                               | start high, busy low
//  result   | status_o, data_o, count_o, is_full_o,            | result_valid_o strobe,
//           | is_empty_o, last_o                               | one cycle, no back-pressure
//  config   | cfg_wdata_i                                      | cfg_we_i high
//
// Enqueue, dequeue and query give their beat in the following cycle; while busy is low,
// a new command may be accepted every cycle. Display of n words reads the ring one slot
// per cycle through the registered memory read port, giving n beats, and holds busy high
// from the second read to the last. Reset empties the queue and sets the capacity to 16
// at once; the ring contents are not cleared. The receiver cannot stall the result beats.
`default_nettype none

module circular_queue_core #(
  parameter int unsigned DEPTH = cq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [cq_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [cq_pkg::DATA_W-1:0] value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [cq_pkg::CAP_W-1:0]         cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic [cq_pkg::STAT_W-1:0]             status_o,
  output logic signed [cq_pkg::DATA_W-1:0]      data_o,
  output logic [cq_pkg::CNT_W-1:0]              count_o,
  output logic                                  is_full_o,
  output logic                                  is_empty_o,
  output logic                                  last_o
);

  import cq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  cq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .busy      (busy),
    .ctrl_o    (ctrl)
  );

  cq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .data_o         (data_o),
    .count_o        (count_o),
    .is_full_o      (is_full_o),
    .is_empty_o     (is_empty_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cq_ctrl.sv =====
// Controller state machine: decodes commands and sequences the display stream.
`default_nettype none

module cq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic [cq_pkg::CMD_W-1:0] command_i,
  input  wire cq_pkg::stat_t       stat_i,
  output logic                     busy,
  output cq_pkg::ctrl_t            ctrl_o
);

  import cq_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SHOW = 1'b1;

  logic [0:0]       state_q, state_d;
  logic [CNT_W-1:0] remain_q, remain_d;

  always_comb begin
    state_d     = state_q;
    remain_d    = remain_q;
    ctrl_o.op   = OP_IDLE;
    ctrl_o.last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.last = 1'b1;
          case (command_i)
            CMD_ENQ:   ctrl_o.op = stat_i.full ? OP_FULL : OP_ENQ;
            CMD_DEQ:   ctrl_o.op = stat_i.empty ? OP_EMPTY : OP_DEQ;
            CMD_QUERY: ctrl_o.op = OP_QUERY;
            CMD_SHOW: begin
              if (stat_i.empty) begin
                ctrl_o.op = OP_EMPTY;
              end else begin
                ctrl_o.op   = OP_SHOW_FIRST;
                ctrl_o.last = (stat_i.count == CNT_W'(1));
                remain_d    = stat_i.count - CNT_W'(1);
                if (stat_i.count != CNT_W'(1)) begin
                  state_d = S_SHOW;
                end
              end
            end
            default: ctrl_o.op = OP_IDLE;
          endcase
        end
      end
      S_SHOW: begin
        ctrl_o.op   = OP_SHOW_NEXT;
        ctrl_o.last = (remain_q == CNT_W'(1));
        remain_d    = remain_q - CNT_W'(1);
        if (remain_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q == S_SHOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
    end
  end

  a_show_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHOW) |-> (remain_q != '0))
    else $error("display stream running with nothing left to send");

  a_show_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHOW && remain_q == CNT_W'(1)) |=> (state_q == S_IDLE))
    else $error("display stream did not end after its last beat");

  a_show_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == OP_SHOW_FIRST && !ctrl_o.last) |=> (state_q == S_SHOW))
    else $error("multi-word display did not enter the stream state");

endmodule

`default_nettype wire

// ===== hw/rtl/cq_datapath.sv =====
// Datapath: ring storage, head and tail indices, fill count and result registers.
`default_nettype none

module cq_datapath #(
  parameter int unsigned DEPTH = cq_pkg::DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cq_pkg::ctrl_t                ctrl_i,
  input  wire logic signed [cq_pkg::DATA_W-1:0] value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [cq_pkg::CAP_W-1:0]     cfg_wdata_i,
  output cq_pkg::stat_t                     stat_o,
  output logic                              result_valid_o,
  output logic [cq_pkg::STAT_W-1:0]         status_o,
  output logic signed [cq_pkg::DATA_W-1:0]  data_o,
  output logic [cq_pkg::CNT_W-1:0]          count_o,
  output logic                              is_full_o,
  output logic                              is_empty_o,
  output logic                              last_o
);

  import cq_pkg::*;

  localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW  = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
  localparam int unsigned LIM = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

  logic signed [DATA_W-1:0] slots [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] eff_c;
  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, show_q, show_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;

  logic              res_valid_q;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_count_q;
  logic              res_full_q, res_empty_q, res_last_q;
  logic              data_sel_q, data_sel_d;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x,
                                             input logic [CNT_W-1:0] c);
    logic [XW-1:0] nx;
    begin
      nx = XW'(x) + XW'(1);
      return (nx == XW'(c)) ? '0 : nx[IW-1:0];
    end
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      eff_c = CNT_W'(1);
    end else if (cap_q > LIM_C) begin
      eff_c = LIM_C;
    end else begin
      eff_c = cap_q;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q >= eff_c);
  assign stat_o.count = count_q;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    show_d       = show_q;
    count_d      = count_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = '0;
    raddr        = head_q;
    res_status_d = ST_QUERY;
    data_sel_d   = 1'b0;
    case (ctrl_i.op)
      OP_ENQ: begin
        we           = 1'b1;
        waddr        = (count_q == '0) ? '0 : wrap_inc(tail_q, eff_c);
        tail_d       = waddr;
        if (count_q == '0) begin
          head_d = '0;
        end
        count_d      = count_q + CNT_W'(1);
        res_status_d = ST_ENQ;
      end
      OP_FULL:  res_status_d = ST_FULL;
      OP_DEQ: begin
        re = 1'b1;
        if (head_q == tail_q) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = wrap_inc(head_q, eff_c);
        end
        count_d      = count_q - CNT_W'(1);
        res_status_d = ST_DEQ;
        data_sel_d   = 1'b1;
      end
      OP_EMPTY: res_status_d = ST_EMPTY;
      OP_QUERY: res_status_d = ST_QUERY;
      OP_SHOW_FIRST: begin
        re           = 1'b1;
        show_d       = wrap_inc(head_q, eff_c);
        res_status_d = ST_SHOW;
        data_sel_d   = 1'b1;
      end
      OP_SHOW_NEXT: begin
        re           = 1'b1;
        raddr        = show_q;
        show_d       = wrap_inc(show_q, eff_c);
        res_status_d = ST_SHOW;
        data_sel_d   = 1'b1;
      end
      default: res_status_d = ST_QUERY;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slots[waddr] <= value_i;
    end
    if (re) begin
      rdata_q <= slots[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      show_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (ctrl_i.op != OP_IDLE);
      show_q      <= show_d;
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_count_q  <= count_d;
    res_full_q   <= (count_d == eff_c);
    res_empty_q  <= (count_d == '0);
    res_last_q   <= ctrl_i.last;
    data_sel_q   <= data_sel_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign data_o         = data_sel_q ? rdata_q : '0;
  assign count_o        = res_count_q;
  assign is_full_o      = res_full_q;
  assign is_empty_o     = res_empty_q;
  assign last_o         = res_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= eff_c)
    else $error("fill count exceeds the capacity in use");

  a_empty_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with indices away from slot zero");

  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DEQ && !cfg_we_i) |=> (res_valid_q && res_status_q == ST_DEQ))
    else $error("dequeue gave no dequeued beat");

endmodule

`default_nettype wire

// ===== tb/circular_queue_checker.sv =====
// Checker for the circular queue core: predicts every result beat and compares it field by field.
module circular_queue_checker
  import cq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [CMD_W-1:0]         command_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                     beat_valid_i,
  input  wire logic [STAT_W-1:0]        status_i,
  input  wire logic signed [DATA_W-1:0] data_i,
  input  wire logic [CNT_W-1:0]         count_i,
  input  wire logic                     full_i,
  input  wire logic                     empty_i,
  input  wire logic                     last_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned RING      = DEPTH_DEF;
  localparam int unsigned IDX_W     = $clog2(RING);
  localparam int unsigned CAP_LIMIT = (DEPTH_DEF < MAX_RESULTS) ? DEPTH_DEF : MAX_RESULTS;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              empty;
    logic              last;
  } beat_t;

  logic [CAP_W-1:0]  capacity_q;
  logic [IDX_W-1:0]  head_q;
  logic [IDX_W-1:0]  tail_q;
  logic              empty_q;
  logic [DATA_W-1:0] ring_q [RING];
  beat_t             beats_due [$];

  function automatic int unsigned slots_in_use();
    int unsigned c;
    c = capacity_q;
    if (c < 1) c = 1;
    if (c > CAP_LIMIT) c = CAP_LIMIT;
    return c;
  endfunction

  function automatic int unsigned words_held();
    int unsigned c;
    c = slots_in_use();
    if (empty_q) return 0;
    return ((tail_q + c - head_q) % c) + 1;
  endfunction

  function automatic beat_t shape_beat(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                       logic last);
    beat_t       b;
    int unsigned n;
    n = words_held();
    b.status = status;
    b.data   = data;
    b.count  = n[CNT_W-1:0];
    b.full   = (n == slots_in_use());
    b.empty  = (n == 0);
    b.last   = last;
    return b;
  endfunction

  task automatic empty_ring();
    head_q  = '0;
    tail_q  = '0;
    empty_q = 1'b1;
  endtask

  task automatic predict_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    int unsigned       c;
    int unsigned       n;
    int unsigned       idx;
    logic [DATA_W-1:0] got;
    c = slots_in_use();
    case (cmd)
      CMD_ENQ: begin
        if (words_held() >= c) begin
          beats_due.push_back(shape_beat(ST_FULL, '0, 1'b1));
        end else begin
          if (empty_q) begin
            head_q  = '0;
            tail_q  = '0;
            empty_q = 1'b0;
          end else begin
            tail_q = IDX_W'((tail_q + 1) % c);
          end
          ring_q[tail_q] = word;
          beats_due.push_back(shape_beat(ST_ENQ, '0, 1'b1));
        end
      end
      CMD_DEQ: begin
        if (empty_q) begin
          beats_due.push_back(shape_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          got = ring_q[head_q];
          if (head_q == tail_q) empty_ring();
          else head_q = IDX_W'((head_q + 1) % c);
          beats_due.push_back(shape_beat(ST_DEQ, got, 1'b1));
        end
      end
      CMD_QUERY: begin
        beats_due.push_back(shape_beat(ST_QUERY, '0, 1'b1));
      end
      default: begin
        n   = words_held();
        idx = head_q;
        if (n == 0) begin
          beats_due.push_back(shape_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            beats_due.push_back(shape_beat(ST_SHOW, ring_q[idx], k + 1 == n));
            idx = (idx + 1) % c;
          end
        end
      end
    endcase
  endtask

  task automatic check_beat(beat_t got);
    beat_t want;
    if (beats_due.size() == 0) begin
      if (fail_count_o < 10)
        $display("unexpected beat: status %0d data %0d count %0d full %0b empty %0b last %0b",
                 got.status, $signed(got.data), got.count, got.full, got.empty, got.last);
      fail_count_o++;
    end else begin
      want = beats_due.pop_front();
      if (got !== want) begin
        if (fail_count_o < 10) begin
          $display("beat mismatch: expected status %0d data %0d count %0d full %0b empty %0b last %0b",
                   want.status, $signed(want.data), want.count, want.full, want.empty, want.last);
          $display("                    got status %0d data %0d count %0d full %0b empty %0b last %0b",
                   got.status, $signed(got.data), got.count, got.full, got.empty, got.last);
        end
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i) begin : watch
    beat_t seen;
    if (!rst_ni) begin
      capacity_q = CAP_RESET;
      empty_ring();
      beats_due.delete();
      fail_count_o = 0;
    end else begin
      if (beat_valid_i) begin
        seen.status = status_i;
        seen.data   = data_i;
        seen.count  = count_i;
        seen.full   = full_i;
        seen.empty  = empty_i;
        seen.last   = last_i;
        check_beat(seen);
      end
      if (cfg_we_i) begin
        capacity_q = cfg_wdata_i;
        empty_ring();
      end
      if (start_i && !busy_i) predict_command(command_i, value_i);
    end
    pending_o = beats_due.size();
  end

endmodule

// ===== tb/circular_queue_core_tb.sv =====
// Testbench top for the circular queue core: clock, reset, command stimulus and verdict.
module circular_queue_core_tb;
  import cq_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     cfg_we_i;
  logic [CAP_W-1:0]         cfg_wdata_i;
  logic                     result_valid_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] data_o;
  logic [CNT_W-1:0]         count_o;
  logic                     is_full_o;
  logic                     is_empty_o;
  logic                     last_o;
  int                       fail_count;
  int                       pending;
  int                       burst_left;
  int                       idle_cycles;

  circular_queue_core #(
    .DEPTH(DEPTH_DEF)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .data_o        (data_o),
    .count_o       (count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o),
    .last_o        (last_o)
  );

  circular_queue_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .command_i   (command_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .beat_valid_i(result_valid_o),
    .status_i    (status_o),
    .data_i      (data_o),
    .count_i     (count_o),
    .full_i      (is_full_o),
    .empty_i     (is_empty_o),
    .last_i      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("circular_queue_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int unsigned enq_share);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CMD_QUERY;
    if (r < 20) return CMD_SHOW;
    if (r < 20 + enq_share * 80 / 100) return CMD_ENQ;
    return CMD_DEQ;
  endfunction

  task automatic send(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    @(negedge clk_i);
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    burst_left = 0;
  endtask

  initial begin : stimulus
    int unsigned cap_list [8];
    int unsigned cap;
    int unsigned eff;
    int unsigned items;
    cap_list    = '{16, 1, 31, 17, 2, 0, 5, 3};
    rst_ni      = 1'b0;
    start       = 1'b0;
    command_i   = CMD_QUERY;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CAP_RESET;
    burst_left  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue at reset capacity, extreme words, drain past the last word.
    send(CMD_QUERY, '0);
    send(CMD_DEQ, '0);
    send(CMD_SHOW, '0);
    send(CMD_ENQ, 32'h7FFF_FFFF);
    send(CMD_ENQ, 32'h8000_0000);
    send(CMD_ENQ, 32'h0000_0000);
    send(CMD_ENQ, 32'hFFFF_FFFF);
    send(CMD_QUERY, '0);
    send(CMD_SHOW, '0);
    repeat (5) send(CMD_DEQ, '0);

    // A capacity of zero acts as one slot.
    write_capacity(CAP_W'(0));
    send(CMD_ENQ, $urandom);
    send(CMD_ENQ, $urandom);
    send(CMD_QUERY, '0);
    send(CMD_SHOW, '0);
    send(CMD_DEQ, '0);

    // Two slots: fill, reject, wrap the tail and read back.
    write_capacity(CAP_W'(2));
    send(CMD_ENQ, $urandom);
    send(CMD_ENQ, $urandom);
    send(CMD_ENQ, $urandom);
    send(CMD_DEQ, '0);
    send(CMD_ENQ, $urandom);
    send(CMD_SHOW, '0);
    send(CMD_DEQ, '0);
    send(CMD_DEQ, '0);

    for (int p = 0; p < 9; p++) begin
      cap = (p < 8) ? cap_list[p] : $urandom_range(0, 31);
      eff = (cap == 0) ? 1 : ((cap > MAX_RESULTS) ? MAX_RESULTS : cap);
      items = 12 + 2 * eff;
      write_capacity(CAP_W'(cap));
      for (int unsigned k = 0; k < items; k++)
        send(pick_command((k < items * 6 / 10) ? 75 : 25), pick_word());
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("circular_queue_core verification clean");
    end else begin
      $display("circular_queue_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cq_pkg.sv
hw/rtl/cq_ctrl.sv
hw/rtl/cq_datapath.sv
hw/rtl/circular_queue_core.sv
tb/circular_queue_checker.sv
tb/circular_queue_core_tb.sv
